>>> src/crd_pkg.sv
package crd_pkg;

  localparam int unsigned MaxItemsDefault = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned IdxW = 6;

  typedef struct packed {
    logic signed [ValueW-1:0] sample_value;
    logic                     is_last;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] position;
    logic [IdxW-1:0] greater_count;
    logic            overflowed;
    logic            end_of_run;
  } result_t;

  // Program steps of the sequencer.
  typedef enum logic [2:0] {
    StIdle  = 3'd0,
    StReadI = 3'd1,
    StKey   = 3'd2,
    StCmp   = 3'd3,
    StEmit  = 3'd4
  } step_e;

  // Jump conditions a control word can test.
  typedef enum logic [1:0] {
    CondNone  = 2'd0,
    CondClose = 2'd1,
    CondJEnd  = 2'd2,
    CondIEnd  = 2'd3
  } cond_e;

  typedef struct packed {
    logic  take;    // the step accepts a request
    logic  clr_i;   // restart the outer index
    logic  rd_i;    // read address from the outer index, else zero on key_ld or the next inner index
    logic  key_ld;  // latch the key, clear inner index and count
    logic  cmp;     // compare one stored value and advance the inner index
    logic  emit;    // present one rank and advance the outer index
    cond_e cond;
    step_e tgt_t;   // next step when the condition holds
    step_e tgt_f;   // next step otherwise
  } ctl_t;

  // Status the datapath hands back to the sequencer.
  typedef struct packed {
    logic close;
    logic j_end;
    logic i_end;
  } stat_t;

  function automatic ctl_t ctl_rom(step_e s);
    ctl_t w;
    w = '{take: 1'b0, clr_i: 1'b0, rd_i: 1'b0, key_ld: 1'b0, cmp: 1'b0, emit: 1'b0,
          cond: CondNone, tgt_t: StIdle, tgt_f: StIdle};
    unique case (s)
      StIdle: begin
        w.take = 1'b1; w.clr_i = 1'b1;
        w.cond = CondClose; w.tgt_t = StReadI; w.tgt_f = StIdle;
      end
      StReadI: begin
        w.rd_i = 1'b1; w.tgt_t = StKey; w.tgt_f = StKey;
      end
      StKey: begin
        w.key_ld = 1'b1; w.tgt_t = StCmp; w.tgt_f = StCmp;
      end
      StCmp: begin
        w.cmp = 1'b1;
        w.cond = CondJEnd; w.tgt_t = StEmit; w.tgt_f = StCmp;
      end
      StEmit: begin
        w.emit = 1'b1;
        w.cond = CondIEnd; w.tgt_t = StIdle; w.tgt_f = StReadI;
      end
      default: begin
        w.tgt_t = StIdle; w.tgt_f = StIdle;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/crd_seq.sv
module crd_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crd_pkg::stat_t stat_i,
  output crd_pkg::ctl_t  ctl_o
);

  crd_pkg::step_e step_q, step_d;
  logic           hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= crd_pkg::StIdle;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    ctl_o = crd_pkg::ctl_rom(step_q);
    unique case (ctl_o.cond)
      crd_pkg::CondClose: hit = stat_i.close;
      crd_pkg::CondJEnd:  hit = stat_i.j_end;
      crd_pkg::CondIEnd:  hit = stat_i.i_end;
      default:            hit = 1'b1;
    endcase
    step_d = hit ? ctl_o.tgt_t : ctl_o.tgt_f;
  end

endmodule

>>> src/crd_datapath.sv
module crd_datapath #(
  parameter int unsigned MaxItems = crd_pkg::MaxItemsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crd_pkg::ctl_t    ctl_i,
  input  logic             start_i,
  input  crd_pkg::in_req_t req_i,
  output crd_pkg::stat_t   stat_o,
  output logic             res_valid_o,
  output crd_pkg::result_t res_o
);

  localparam int unsigned AddrW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CntW  = $clog2(MaxItems + 1);

  logic signed [crd_pkg::ValueW-1:0] mem [MaxItems];
  logic signed [crd_pkg::ValueW-1:0] rdata_q, key_q;
  logic [CntW-1:0]          count_q;
  logic                     ovf_q;
  logic [AddrW-1:0]         i_q, j_q, raddr, last_idx;
  logic [crd_pkg::IdxW-1:0] gt_q;
  logic                     accept, full, res_valid_q;
  crd_pkg::result_t         res_q;

  assign accept   = start_i & ctl_i.take;
  assign full     = (count_q == CntW'(MaxItems));
  assign last_idx = AddrW'(count_q - CntW'(1));
  assign raddr    = ctl_i.rd_i ? i_q : (ctl_i.key_ld ? '0 : AddrW'(j_q + AddrW'(1)));

  assign stat_o.close = accept & req_i.is_last;
  assign stat_o.j_end = (j_q == last_idx);
  assign stat_o.i_end = (i_q == last_idx);

  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      mem[count_q[AddrW-1:0]] <= req_i.sample_value;
    end
    rdata_q <= mem[raddr];
    if (ctl_i.key_ld) begin
      key_q <= rdata_q;
    end
    if (ctl_i.emit) begin
      res_q.position      <= crd_pkg::IdxW'(i_q);
      res_q.greater_count <= gt_q;
      res_q.overflowed    <= ovf_q;
      res_q.end_of_run    <= stat_o.i_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      gt_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.emit;
      if (accept) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end
      if (ctl_i.clr_i) begin
        i_q <= '0;
      end
      if (ctl_i.key_ld) begin
        j_q  <= '0;
        gt_q <= '0;
      end
      if (ctl_i.cmp) begin
        j_q  <= AddrW'(j_q + AddrW'(1));
        gt_q <= gt_q + crd_pkg::IdxW'(rdata_q > key_q);
      end
      if (ctl_i.emit) begin
        i_q <= AddrW'(i_q + AddrW'(1));
        if (stat_o.i_end) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> src/counting_rank_descending.sv
// Descending rank of every value in a set. Values arrive as requests on start while busy
// is low, one per cycle, and are stored in arrival order up to MaxItems; further values are
// dropped and mark the results as overflowed. The request that carries is_last closes the
// set, raises busy, and the block then reports, in arrival order, how many set values are
// strictly greater than each stored one, comparing signed Q16.16 words as signed integers.
// For each stored value in turn, the block reads it from the value store, latches it as
// the key, sweeps the store through its single read port, and presents the result. Busy
// falls in the cycle that shows the last rank of the set. Each rank is shown on res_o for
// exactly one cycle with res_valid_o high, and the receiver cannot stall it, so it must
// take every rank as it appears. Control comes from a five-step program in a read-only
// table; a step counter walks it with conditional jumps on the closing request and at the
// end of each sweep and set.
module counting_rank_descending #(
  parameter int unsigned MaxItems = crd_pkg::MaxItemsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  crd_pkg::in_req_t req_i,
  output logic             res_valid_o,
  output crd_pkg::result_t res_o
);

  crd_pkg::ctl_t  ctl;
  crd_pkg::stat_t stat;

  // The sequencer only takes a request in its idle step.
  assign busy = ~ctl.take;

  crd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  crd_datapath #(
    .MaxItems (MaxItems)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .start_i     (start),
    .req_i       (req_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // The final rank of a set is shown as the block returns to idle.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.end_of_run |-> !busy)
    else $error("block still busy after the final rank");

  // Ranks only come out of a ranking pass.
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("rank shown without a ranking pass");

  // A request that does not close the set keeps the block ready.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !req_i.is_last |=> !busy)
    else $error("block went busy on a request that did not close the set");

  // A closing request always starts a ranking pass.
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.is_last |=> busy && !res_valid_o)
    else $error("closing request did not start ranking");

endmodule

>>> bench/counting_rank_descending_test.sv
`timescale 1ns / 100ps

module counting_rank_descending_test;

  localparam int unsigned MaxItems = crd_pkg::MaxItemsDefault;
  // Long enough to rank one more value of a full store, so this covers any late rank.
  localparam int unsigned TailCycles = MaxItems + 16;
  // Cycles to wait for the last expected ranks once every request is in.
  localparam int unsigned DrainLimit = 40000;
  // Time limit for the whole run; a hang ends it with NOT OK.
  localparam longint unsigned TimeoutNs = 64'd3_200_000;
  localparam int unsigned RandomRequests = 200;
  localparam int unsigned PrintLimit = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  crd_pkg::in_req_t  req_i;
  logic              res_valid_o;
  crd_pkg::result_t  res_o;

  // Shadow of the block: the values of the set now being loaded, how many were
  // stored, and whether any of them was dropped for lack of room.
  logic signed [crd_pkg::ValueW-1:0] set_values [MaxItems];
  int unsigned set_count;
  logic        set_dropped;

  // Ranks the block still owes, oldest first.
  crd_pkg::result_t pending_ranks[$];
  crd_pkg::result_t front_rank;

  int unsigned requests_sent;
  int unsigned sets_closed;
  int unsigned overflow_sets;
  int unsigned ranks_checked;
  int unsigned error_count;
  int unsigned burst_left;

  counting_rank_descending #(
    .MaxItems(MaxItems)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every failure goes through here; printing stops after a while so that a badly
  // broken block cannot flood the log, but the count keeps going.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PrintLimit) begin
      $display("%0t ns: MISMATCH %s", $time, msg);
    end
  endtask

  // Apply one accepted request to the shadow state. A value that finds the set full
  // is dropped and marks the set as overflowed. The request carrying is_last closes
  // the set: every stored value, in arrival order, gets the number of set values
  // strictly greater than it, so ties share a rank and the largest gets zero.
  function automatic void predict_ranks(input crd_pkg::in_req_t r);
    int unsigned      i;
    int unsigned      j;
    int unsigned      greater;
    crd_pkg::result_t rank;
    if (set_count < MaxItems) begin
      set_values[set_count] = r.sample_value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (r.is_last) begin
      for (i = 0; i < set_count; i++) begin
        greater = 0;
        for (j = 0; j < set_count; j++) begin
          if (set_values[j] > set_values[i]) begin
            greater++;
          end
        end
        rank.position      = crd_pkg::IdxW'(i);
        rank.greater_count = crd_pkg::IdxW'(greater);
        rank.overflowed    = set_dropped;
        rank.end_of_run    = (i + 1 == set_count);
        pending_ranks.push_back(rank);
      end
      sets_closed++;
      if (set_dropped) begin
        overflow_sets++;
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // Send one request. The sender runs in bursts: when a burst is used up it drops
  // start for a while and picks a new burst length. Long bursts give stretches
  // with no idling at all. The request is held until an edge finds busy low.
  task automatic send_request(input logic signed [crd_pkg::ValueW-1:0] sample,
                              input logic closing);
    crd_pkg::in_req_t r;
    r.sample_value = sample;
    r.is_last      = closing;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end else begin
      burst_left--;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    predict_ranks(r);
    requests_sent++;
  endtask

  // Random sample values: full-range words, a few extremes, and narrow ranges that
  // produce plenty of ties, both on whole Q16.16 steps and on raw low bits.
  function automatic logic signed [crd_pkg::ValueW-1:0] random_sample();
    logic signed [crd_pkg::ValueW-1:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom;
      end
      1: begin
        v = ($signed($urandom_range(0, 6)) - 3) <<< 16;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh0000_0000;
          default: v = 32'shFFFF_FFFF;
        endcase
      end
      default: begin
        v = $signed($urandom_range(0, 15)) - 8;
      end
    endcase
    return v;
  endfunction

  // Send a whole set of random values; only its final request carries is_last.
  task automatic send_random_set(input int unsigned size);
    int unsigned k;
    for (k = 0; k < size; k++) begin
      send_request(random_sample(), k + 1 == size);
    end
  endtask

  // A set of one value: it must rank zero and end the run on its own.
  task automatic test_lone_value();
    send_request(32'sh0001_0000, 1'b1);
  endtask

  // The most positive and most negative words, zero, minus one and their neighbors.
  // Between them every bit of the value goes both ways, and the signed order is
  // tested right at the wrap point.
  task automatic test_extremes();
    send_request(32'sh7FFF_FFFF, 1'b0);
    send_request(32'sh8000_0000, 1'b0);
    send_request(32'sh0000_0000, 1'b0);
    send_request(32'shFFFF_FFFF, 1'b0);
    send_request(32'sh0000_0001, 1'b0);
    send_request(32'sh8000_0001, 1'b0);
    send_request(32'sh7FFF_FFFE, 1'b1);
  endtask

  // Equal values must share a rank; two groups of ties interleaved.
  task automatic test_ties();
    send_request(32'sh0002_8000, 1'b0);
    send_request(-32'sh0001_8000, 1'b0);
    send_request(32'sh0002_8000, 1'b0);
    send_request(-32'sh0001_8000, 1'b0);
    send_request(32'sh0002_8000, 1'b1);
  endtask

  // A set that fills the store exactly, then one that spills over so that the
  // closing value itself is dropped but still closes the set.
  task automatic test_capacity();
    send_random_set(MaxItems);
    send_random_set(MaxItems + 5);
  endtask

  // Mostly short sets, which keep the run fast, with now and then one that is near,
  // at or beyond capacity.
  task automatic test_random_sets();
    int unsigned first;
    int unsigned size;
    first = requests_sent;
    while (requests_sent - first < RandomRequests) begin
      if ($urandom_range(0, 14) == 0) begin
        size = $urandom_range(MaxItems - 2, MaxItems + 6);
      end else begin
        size = $urandom_range(1, 10);
      end
      send_random_set(size);
    end
  endtask

  // Each rank is on the result port for one cycle only, so it is taken at every
  // edge where the strobe is high and compared with the oldest rank still owed.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_ranks.size() == 0) begin
        report_mismatch($sformatf("rank for position %0d arrived with none expected",
                                  res_o.position));
      end else begin
        front_rank = pending_ranks.pop_front();
        ranks_checked++;
        if (res_o.position !== front_rank.position) begin
          report_mismatch($sformatf("position %0d, expected %0d",
                                    res_o.position, front_rank.position));
        end
        if (res_o.greater_count !== front_rank.greater_count) begin
          report_mismatch($sformatf("position %0d: greater_count %0d, expected %0d",
                                    front_rank.position, res_o.greater_count,
                                    front_rank.greater_count));
        end
        if (res_o.overflowed !== front_rank.overflowed) begin
          report_mismatch($sformatf("position %0d: overflowed %0b, expected %0b",
                                    front_rank.position, res_o.overflowed,
                                    front_rank.overflowed));
        end
        if (res_o.end_of_run !== front_rank.end_of_run) begin
          report_mismatch($sformatf("position %0d: end_of_run %0b, expected %0b",
                                    front_rank.position, res_o.end_of_run,
                                    front_rank.end_of_run));
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    set_count     = 0;
    set_dropped   = 1'b0;
    requests_sent = 0;
    sets_closed   = 0;
    overflow_sets = 0;
    ranks_checked = 0;
    error_count   = 0;
    burst_left    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_lone_value();
    test_extremes();
    test_ties();
    test_capacity();
    test_random_sets();

    @(negedge clk_i);
    start <= 1'b0;

    // Let the last set be ranked, then watch a while longer for stray ranks.
    waited = 0;
    while (pending_ranks.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_ranks.size() != 0) begin
      report_mismatch($sformatf("%0d ranks never arrived", pending_ranks.size()));
    end

    $display("Ranked %0d sets from %0d requests, %0d of the sets overflowed.",
             sets_closed, requests_sent, overflow_sets);
    $display("Checked %0d ranks, %0d mismatches.", ranks_checked, error_count);
    if (error_count == 0) begin
      $display("counting_rank_descending_test OK");
    end else begin
      $display("counting_rank_descending_test NOT OK");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Timed out after %0d requests and %0d ranks.", requests_sent, ranks_checked);
    $display("counting_rank_descending_test NOT OK");
    $finish;
  end

endmodule
